// ===== src/mmeu_pkg.sv =====
// shared types and codes for the memory-to-memory execute unit
package mmeu_pkg;

  localparam logic [3:0] CMD_ADD    = 4'd0;
  localparam logic [3:0] CMD_MUL    = 4'd1;
  localparam logic [3:0] CMD_LE     = 4'd2;
  localparam logic [3:0] CMD_NEG    = 4'd3;
  localparam logic [3:0] CMD_ASSIGN = 4'd4;
  localparam logic [3:0] CMD_JZ     = 4'd5;
  localparam logic [3:0] CMD_JUMP   = 4'd6;
  localparam logic [3:0] CMD_READ   = 4'd7;
  localparam logic [3:0] CMD_WRITE  = 4'd8;
  localparam logic [3:0] CMD_HALT   = 4'd9;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_RANGE   = 2'd1;
  localparam logic [1:0] ST_HALTED  = 2'd2;

  typedef struct packed {
    logic [3:0]  cmd;
    logic [31:0] a_val;
    logic [31:0] b_val;
    logic        a_ok;
    logic        b_ok;
    logic        dest_ok;
    logic        target_ok;
    logic [9:0]  target;
    logic [31:0] read_value;
    logic        halted;
  } exec_op_t;

  typedef struct packed {
    logic        we;
    logic [31:0] wdata;
    logic [31:0] print_value;
    logic        print_valid;
    logic        jump_taken;
    logic [9:0]  new_pc;
    logic        halt_set;
    logic [1:0]  status;
  } exec_res_t;

endpackage

// ===== src/memory_to_memory_execute_unit_core.sv =====
// execute unit top: operand fetch, write-back with forwarding, result register
// an accepted item passes the fetch register, then the result register that raises m_tvalid
// throughput: one item per cycle while m_tready keeps the result register free, set by the
//   fetch from two mirrored data memories with forwarding from the most recent write-back
// reset: clears the halt flag, then a clearing pass zeroes all MEM_WORDS words of
//   the data memory with s_tready held low
module memory_to_memory_execute_unit_core #(
  parameter int MEM_WORDS     = 1024,
  parameter int PROGRAM_WORDS = 1024
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // command[3:0], operand_a[35:4], operand_b[67:36], dest_address[77:68],
  // jump_target[87:78], read_value[119:88]
  input  logic [119:0] s_tdata,
  // a_is_address[0], b_is_address[1]
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // print_value[31:0], jump_taken[32], new_pc[42:33], halted[43], status[45:44]
  output logic [47:0]  m_tdata,
  // print_valid[0]
  output logic [0:0]   m_tuser
);

  localparam int AW = $clog2(MEM_WORDS);

  logic [3:0]  in_cmd;
  logic [31:0] in_a;
  logic [31:0] in_b;
  logic [9:0]  in_dest;
  logic [9:0]  in_target;
  logic [31:0] in_read;
  logic        accept;
  logic        out_free;
  logic        s1_move;

  logic          clearing;
  logic [AW-1:0] clr_addr;

  logic          s1_valid;
  logic [3:0]    s1_cmd;
  logic [31:0]   s1_a;
  logic [31:0]   s1_b;
  logic          s1_a_is;
  logic          s1_b_is;
  logic          s1_a_ok;
  logic          s1_b_ok;
  logic          s1_dest_ok;
  logic          s1_target_ok;
  logic [AW-1:0] s1_dest;
  logic [9:0]    s1_target;
  logic [31:0]   s1_read;

  logic          lw_valid;
  logic [AW-1:0] lw_addr;
  logic [31:0]   lw_data;

  logic          halt_flag;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;
  logic [31:0]   rdata_a;
  logic [31:0]   rdata_b;

  mmeu_pkg::exec_op_t  op;
  mmeu_pkg::exec_res_t res;

  assign in_cmd    = s_tdata[3:0];
  assign in_a      = s_tdata[35:4];
  assign in_b      = s_tdata[67:36];
  assign in_dest   = s_tdata[77:68];
  assign in_target = s_tdata[87:78];
  assign in_read   = s_tdata[119:88];

  assign out_free = !m_tvalid || m_tready;
  assign s1_move  = s1_valid && out_free;
  assign s_tready = !clearing && (!s1_valid || out_free);
  assign accept   = s_tvalid && s_tready;

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(MEM_WORDS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_comb begin
    if (clearing) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else begin
      mem_we    = s1_move && res.we;
      mem_waddr = s1_dest;
      mem_wdata = res.wdata;
    end
  end

  mmeu_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_ram_a (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (accept),
    .raddr (in_a[AW-1:0]),
    .rdata (rdata_a)
  );

  mmeu_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_ram_b (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (accept),
    .raddr (in_b[AW-1:0]),
    .rdata (rdata_b)
  );

  // fetch stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd       <= in_cmd;
      s1_a         <= in_a;
      s1_b         <= in_b;
      s1_a_is      <= s_tuser[0];
      s1_b_is      <= s_tuser[1];
      s1_a_ok      <= !s_tuser[0] || (!in_a[31] && (in_a < 32'(MEM_WORDS)));
      s1_b_ok      <= !s_tuser[1] || (!in_b[31] && (in_b < 32'(MEM_WORDS)));
      s1_dest_ok   <= {22'd0, in_dest} < 32'(MEM_WORDS);
      s1_target_ok <= {22'd0, in_target} < 32'(PROGRAM_WORDS);
      s1_dest      <= AW'(in_dest);
      s1_target    <= in_target;
      s1_read      <= in_read;
    end
  end

  // last write-back, forwarded over stale ram data
  always_ff @(posedge clk) begin
    if (rst) begin
      lw_valid <= 1'b0;
    end else if (s1_move && res.we) begin
      lw_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && res.we) begin
      lw_addr <= s1_dest;
      lw_data <= res.wdata;
    end
  end

  always_comb begin
    op = '0;
    op.cmd = s1_cmd;
    if (!s1_a_is) begin
      op.a_val = s1_a;
    end else if (lw_valid && lw_addr == s1_a[AW-1:0]) begin
      op.a_val = lw_data;
    end else begin
      op.a_val = rdata_a;
    end
    if (!s1_b_is) begin
      op.b_val = s1_b;
    end else if (lw_valid && lw_addr == s1_b[AW-1:0]) begin
      op.b_val = lw_data;
    end else begin
      op.b_val = rdata_b;
    end
    op.a_ok       = s1_a_ok;
    op.b_ok       = s1_b_ok;
    op.dest_ok    = s1_dest_ok;
    op.target_ok  = s1_target_ok;
    op.target     = s1_target;
    op.read_value = s1_read;
    op.halted     = halt_flag;
  end

  mmeu_alu u_alu (
    .op  (op),
    .res (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      halt_flag <= 1'b0;
    end else if (s1_move && res.halt_set) begin
      halt_flag <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_move) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      m_tdata <= {2'b00, res.status, halt_flag | res.halt_set, res.new_pc,
                  res.jump_taken, res.print_value};
      m_tuser <= res.print_valid;
    end
  end

  a_no_accept_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_tready)
    else $error("item accepted during memory clearing");

  a_write_only_on_commit: assert property (@(posedge clk) disable iff (rst)
    (mem_we && !clearing) |-> (s1_move && s1_dest_ok && !halt_flag))
    else $error("write-back without a committing item");

  a_halt_blocks: assert property (@(posedge clk) disable iff (rst)
    (s1_move && halt_flag) |-> (res.status == mmeu_pkg::ST_HALTED && !res.we
      && !res.jump_taken && !res.print_valid))
    else $error("item executed after halt");

  a_halt_sticks: assert property (@(posedge clk) disable iff (rst)
    halt_flag |=> halt_flag)
    else $error("halt flag dropped");

endmodule

// ===== src/mmeu_ram.sv =====
// generic single-write, single-read ram with registered read
module mmeu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/mmeu_alu.sv =====
// instruction evaluation: arithmetic, compare, assign, jumps, read/write, halt and status
module mmeu_alu (
  input  mmeu_pkg::exec_op_t  op,
  output mmeu_pkg::exec_res_t res
);

  logic        ok;
  logic [31:0] value;
  logic [31:0] product;

  assign product = op.a_val * op.b_val;

  always_comb begin
    res   = '0;
    ok    = 1'b1;
    value = '0;
    unique case (op.cmd) inside
      mmeu_pkg::CMD_ADD, mmeu_pkg::CMD_MUL, mmeu_pkg::CMD_LE: begin
        ok = op.a_ok && op.b_ok;
        if (op.cmd == mmeu_pkg::CMD_ADD) begin
          value = op.a_val + op.b_val;
        end else if (op.cmd == mmeu_pkg::CMD_MUL) begin
          value = product;
        end else begin
          value = {31'd0, ($signed(op.a_val) <= $signed(op.b_val))};
        end
        res.we = 1'b1;
      end
      mmeu_pkg::CMD_NEG, mmeu_pkg::CMD_ASSIGN: begin
        ok = op.a_ok;
        value = (op.cmd == mmeu_pkg::CMD_NEG) ? (32'd0 - op.a_val) : op.a_val;
        res.we = 1'b1;
      end
      mmeu_pkg::CMD_JZ: begin
        ok = op.a_ok;
        if (op.a_ok && op.a_val == 32'd0) begin
          ok = op.target_ok;
          res.jump_taken = 1'b1;
          res.new_pc = op.target;
        end
      end
      mmeu_pkg::CMD_JUMP: begin
        ok = op.target_ok;
        res.jump_taken = 1'b1;
        res.new_pc = op.target;
      end
      mmeu_pkg::CMD_READ: begin
        value = op.read_value;
        res.we = 1'b1;
      end
      mmeu_pkg::CMD_WRITE: begin
        ok = op.a_ok;
        res.print_value = op.a_val;
        res.print_valid = 1'b1;
      end
      mmeu_pkg::CMD_HALT: begin
        res.halt_set = 1'b1;
      end
      default: begin
      end
    endcase
    if (res.we && !op.dest_ok) begin
      ok = 1'b0;
    end
    res.wdata = value;
    if (op.halted) begin
      res = '0;
      res.status = mmeu_pkg::ST_HALTED;
    end else if (!ok) begin
      res = '0;
      res.status = mmeu_pkg::ST_RANGE;
    end
  end

endmodule
